### hdl/cbss_pkg.sv
package cbss_pkg;

    // Longest write sequence that one request can produce.
    localparam int MAX_WRITES = 6;
    localparam int SLOT_W     = $clog2(MAX_WRITES);
    localparam int COUNT_W    = $clog2(MAX_WRITES + 1);

    // Depth of the plan queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request command codes.
    localparam logic CMD_ROM = 1'b0;
    localparam logic CMD_RAM = 1'b1;

    // Bank controller type codes.
    localparam logic [2:0] MBC_NONE = 3'd0;
    localparam logic [2:0] MBC_1    = 3'd1;
    localparam logic [2:0] MBC_2    = 3'd2;
    localparam logic [2:0] MBC_3    = 3'd3;
    localparam logic [2:0] MBC_5    = 3'd4;

    // Adapter bank register selections.
    localparam logic [7:0] SEL_ROM0 = 8'd0;
    localparam logic [7:0] SEL_ROMX = 8'd1;
    localparam logic [7:0] SEL_SRAM = 8'd2;

    // Adapter registers a write can target.
    typedef enum logic [2:0] {
        REG_BANK,
        REG_MODE,
        REG_UPPER,
        REG_ROM_LO,
        REG_ROM_HI9
    } t_reg_sel;

    typedef struct packed {
        logic       cmd;
        logic [1:0] port;
        logic [2:0] mbc_type;
        logic [8:0] bank;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  port_out;
        logic [15:0] write_address;
        logic [7:0]  write_value;
        logic        last;
    } t_out_req;

    typedef struct packed {
        t_reg_sel   sel;
        logic [7:0] value;
    } t_write;

    // One classified request: the full write list and how many entries are live.
    typedef struct packed {
        logic [1:0]                   port;
        logic [COUNT_W-1:0]           count;
        t_write [MAX_WRITES-1:0]      slots;
    } t_plan;

    function automatic logic [15:0] reg_address(input t_reg_sel sel);
        logic [15:0] addr;
        unique case (sel)
            REG_BANK:    addr = 16'hA000;
            REG_MODE:    addr = 16'hE000;
            REG_UPPER:   addr = 16'hC000;
            REG_ROM_LO:  addr = 16'hE100;
            REG_ROM_HI9: addr = 16'hF000;
            default:     addr = 16'hA000;
        endcase
        return addr;
    endfunction

    function automatic t_write mk_write(input t_reg_sel sel, input logic [7:0] value);
        t_write w;
        w.sel   = sel;
        w.value = value;
        return w;
    endfunction

endpackage

### hdl/cbss_front.sv
module cbss_front
    import cbss_pkg::*;
(
    input  t_in_req i_req,
    output t_plan   o_plan
);

    logic [7:0] lo_mask;
    logic [7:0] lo_value;
    logic [7:0] upper;
    logic       special;
    t_write     nop;

    always_comb begin
        unique case (i_req.mbc_type)
            MBC_1:   lo_mask = 8'h1F;
            MBC_2:   lo_mask = 8'h0F;
            MBC_3:   lo_mask = 8'h7F;
            MBC_5:   lo_mask = 8'hFF;
            default: lo_mask = 8'h00;
        endcase
    end

    assign lo_value = i_req.bank[7:0] & lo_mask;
    assign upper    = {6'd0, i_req.bank[6:5]};
    assign special  = (i_req.bank == 9'h020) || (i_req.bank == 9'h040) ||
                      (i_req.bank == 9'h060);
    assign nop      = mk_write(REG_BANK, SEL_ROM0);

    always_comb begin
        o_plan.port  = i_req.port;
        o_plan.count = COUNT_W'(1);
        for (int k = 0; k < MAX_WRITES; k++) begin
            o_plan.slots[k] = nop;
        end

        if (i_req.cmd == CMD_RAM) begin
            o_plan.slots[0] = mk_write(REG_BANK, SEL_ROMX);
            if ((i_req.mbc_type == MBC_1) && (i_req.bank != 9'd0)) begin
                o_plan.slots[1] = mk_write(REG_MODE, 8'd1);
                o_plan.slots[2] = mk_write(REG_UPPER, i_req.bank[7:0]);
                o_plan.slots[3] = mk_write(REG_BANK, SEL_SRAM);
                o_plan.count    = COUNT_W'(4);
            end else begin
                o_plan.slots[1] = mk_write(REG_UPPER, i_req.bank[7:0]);
                o_plan.slots[2] = mk_write(REG_BANK, SEL_SRAM);
                o_plan.count    = COUNT_W'(3);
            end
        end else if (i_req.bank == 9'd0) begin
            o_plan.slots[0] = mk_write(REG_BANK, SEL_ROM0);
            o_plan.count    = COUNT_W'(1);
        end else if (i_req.mbc_type == MBC_1) begin
            o_plan.slots[0] = mk_write(REG_BANK, SEL_ROMX);
            if (special) begin
                // These banks are only reachable through the upper bits in mode 1.
                o_plan.slots[1] = mk_write(REG_BANK, SEL_ROMX);
                o_plan.slots[2] = mk_write(REG_MODE, 8'd1);
                o_plan.slots[3] = mk_write(REG_UPPER, upper);
                o_plan.slots[4] = mk_write(REG_BANK, SEL_ROM0);
                o_plan.count    = COUNT_W'(5);
            end else if (i_req.bank >= 9'h020) begin
                o_plan.slots[1] = mk_write(REG_MODE, 8'd0);
                o_plan.slots[2] = mk_write(REG_UPPER, upper);
                o_plan.slots[3] = mk_write(REG_BANK, SEL_ROM0);
                o_plan.slots[4] = mk_write(REG_ROM_LO, lo_value);
                o_plan.slots[5] = mk_write(REG_BANK, SEL_ROMX);
                o_plan.count    = COUNT_W'(6);
            end else begin
                o_plan.slots[1] = mk_write(REG_UPPER, upper);
                o_plan.slots[2] = mk_write(REG_BANK, SEL_ROM0);
                o_plan.slots[3] = mk_write(REG_ROM_LO, lo_value);
                o_plan.slots[4] = mk_write(REG_BANK, SEL_ROMX);
                o_plan.count    = COUNT_W'(5);
            end
        end else if (i_req.mbc_type == MBC_5) begin
            o_plan.slots[0] = mk_write(REG_ROM_HI9, {7'd0, i_req.bank[8]});
            o_plan.slots[1] = mk_write(REG_BANK, SEL_ROM0);
            o_plan.slots[2] = mk_write(REG_ROM_LO, lo_value);
            o_plan.slots[3] = mk_write(REG_BANK, SEL_ROMX);
            o_plan.count    = COUNT_W'(4);
        end else begin
            o_plan.slots[0] = mk_write(REG_BANK, SEL_ROM0);
            o_plan.slots[1] = mk_write(REG_ROM_LO, lo_value);
            o_plan.slots[2] = mk_write(REG_BANK, SEL_ROMX);
            o_plan.count    = COUNT_W'(3);
        end
    end

endmodule

### hdl/cbss_queue.sv
module cbss_queue
    import cbss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_plan i_plan,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_plan o_plan
);

    t_plan             r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_plan  = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_plan;
        end
    end

endmodule

### hdl/cbss_back.sv
module cbss_back
    import cbss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_plan_valid,
    input  t_plan    i_plan,
    output logic     o_pop,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out_req o_req
);

    logic [SLOT_W-1:0] r_step;
    logic [SLOT_W-1:0] n_step;
    logic              r_valid;
    logic              n_valid;
    t_out_req          r_req;
    t_out_req          n_req;
    logic              load;
    logic              at_end;
    t_write            cur;

    assign load   = i_plan_valid && (!r_valid || i_ready);
    assign at_end = (COUNT_W'(r_step) == i_plan.count - 1'b1);
    assign cur    = i_plan.slots[r_step];
    assign o_pop  = load && at_end;

    always_comb begin
        n_req.port_out      = i_plan.port;
        n_req.write_address = reg_address(cur.sel);
        n_req.write_value   = cur.value;
        n_req.last          = at_end;
    end

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid;
        if (load) begin
            n_step  = at_end ? '0 : r_step + 1'b1;
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

### hdl/cartridge_bank_switch_sequencer_unit.sv
// Bank-switch sequencer for a cartridge adapter. Each request on the input
// channel names a ROM or RAM bank, the adapter slot and the bank controller
// type; the block answers with one to six adapter register writes on the
// output channel, one write per cycle while the output is ready, the final
// one flagged by last. A request has one write for ROM bank zero and up to
// six for MBC1 banks at or above 0x20, and the single-write-per-cycle output
// register sets the sustained rate while it is not held by ready. The
// front classifies a request into its full write list in the cycle it is
// accepted and places it in a two-entry queue; the back walks the list at
// the head of the queue. New requests keep being taken while the queue has
// room, so a request can be accepted while writes of earlier ones are still
// waiting to be taken. The block keeps no state between requests.
module cartridge_bank_switch_sequencer_unit
    import cbss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_in_req  i_req,
    output logic     o_wr_valid,
    input  logic     i_wr_ready,
    output t_out_req o_wr
);

    t_plan front_plan;
    t_plan head_plan;
    logic  queue_full;
    logic  head_valid;
    logic  push;
    logic  pop;

    // A request is taken whenever the queue has a free entry.
    assign o_req_ready = !queue_full;
    assign push        = i_req_valid && !queue_full;

    // The front turns the request into its complete write list.
    cbss_front u_front (
        .i_req  (i_req),
        .o_plan (front_plan)
    );

    // The queue lets the front keep accepting while the back is stalled.
    cbss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plan  (front_plan),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_plan  (head_plan)
    );

    // The back writes once per ready cycle and retires the list on its last write.
    cbss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (head_valid),
        .i_plan       (head_plan),
        .o_pop        (pop),
        .o_valid      (o_wr_valid),
        .i_ready      (i_wr_ready),
        .o_req        (o_wr)
    );

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbss_pkg::*;

    // Adapter register addresses, as seen through the adapter window.
    localparam logic [15:0] ADDR_BANK    = 16'hA000;
    localparam logic [15:0] ADDR_MODE    = 16'hE000;
    localparam logic [15:0] ADDR_UPPER   = 16'hC000;
    localparam logic [15:0] ADDR_ROM_LO  = 16'hE100;
    localparam logic [15:0] ADDR_ROM_HI9 = 16'hF000;

    // Random requests come in two halves, with a full drain after each one.
    localparam int RANDOM_PER_HALF = 118;

    // The receiver holds off once, after this many writes, for this long.
    localparam int HOLD_AT_WRITE = 400;
    localparam int HOLD_CYCLES   = 240;

    // Requests accepted in this window are sent and received with no idling.
    localparam int STEADY_FIRST = 150;
    localparam int STEADY_LAST  = 210;

    localparam int SETTLE_CYCLES = 20;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_req_valid = 1'b0;
    logic     o_req_ready;
    t_in_req  i_req       = '0;
    logic     o_wr_valid;
    logic     i_wr_ready  = 1'b0;
    t_out_req o_wr;

    t_in_req  pending_requests[$];
    t_out_req expected_writes[$];
    t_out_req write_plan[$];

    int requests_taken = 0;
    int writes_seen    = 0;
    int hold_left      = 0;
    int error_count    = 0;

    logic steady;
    assign steady = (requests_taken >= STEADY_FIRST) && (requests_taken < STEADY_LAST);

    cartridge_bank_switch_sequencer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_wr_valid (o_wr_valid),
        .i_wr_ready (i_wr_ready),
        .o_wr       (o_wr)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Reset starts low and is then released for good.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Appends one adapter write to the sequence being worked out.
    function automatic void plan_write(input logic [1:0] port, input logic [15:0] addr,
                                       input logic [7:0] value);
        t_out_req w;
        w.port_out      = port;
        w.write_address = addr;
        w.write_value   = value;
        w.last          = 1'b0;
        write_plan.push_back(w);
    endfunction

    // Works out the full write sequence of one bank-switch request and queues it
    // behind the writes still owed for earlier requests. Only the final write of
    // the sequence carries last.
    function automatic void predict_writes(input t_in_req r);
        logic [7:0] mask;
        logic       done;
        t_out_req   w;
        write_plan.delete();
        done = 1'b0;
        if (r.cmd == CMD_RAM) begin
            // RAM switch: MBC1 needs the mode bit set for any bank other than zero,
            // and the test of zero looks at all nine bits.
            plan_write(r.port, ADDR_BANK, SEL_ROMX);
            if (r.mbc_type == MBC_1 && r.bank != 9'd0)
                plan_write(r.port, ADDR_MODE, 8'd1);
            plan_write(r.port, ADDR_UPPER, r.bank[7:0]);
            plan_write(r.port, ADDR_BANK, SEL_SRAM);
        end else if (r.bank == 9'd0) begin
            plan_write(r.port, ADDR_BANK, SEL_ROM0);
        end else begin
            if (r.mbc_type == MBC_1) begin
                plan_write(r.port, ADDR_BANK, SEL_ROMX);
                if (r.bank >= 9'h020) begin
                    if (r.bank == 9'h020 || r.bank == 9'h040 || r.bank == 9'h060) begin
                        // These banks alias bank zero in the low window, so they
                        // are reached through the upper bits in mode one instead.
                        plan_write(r.port, ADDR_BANK, SEL_ROMX);
                        plan_write(r.port, ADDR_MODE, 8'd1);
                        plan_write(r.port, ADDR_UPPER, {4'd0, r.bank[8:5]});
                        plan_write(r.port, ADDR_BANK, SEL_ROM0);
                        done = 1'b1;
                    end else begin
                        plan_write(r.port, ADDR_MODE, 8'd0);
                    end
                end
                if (!done)
                    plan_write(r.port, ADDR_UPPER, {6'd0, r.bank[6:5]});
            end else if (r.mbc_type == MBC_5) begin
                plan_write(r.port, ADDR_ROM_HI9, {7'd0, r.bank[8]});
            end
            if (!done) begin
                case (r.mbc_type)
                    MBC_1:   mask = 8'h1F;
                    MBC_2:   mask = 8'h0F;
                    MBC_3:   mask = 8'h7F;
                    MBC_5:   mask = 8'hFF;
                    default: mask = 8'h00;
                endcase
                plan_write(r.port, ADDR_BANK, SEL_ROM0);
                plan_write(r.port, ADDR_ROM_LO, r.bank[7:0] & mask);
                plan_write(r.port, ADDR_BANK, SEL_ROMX);
            end
        end
        foreach (write_plan[i]) begin
            w      = write_plan[i];
            w.last = (i == write_plan.size() - 1);
            expected_writes.push_back(w);
        end
    endfunction

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            error_count++;
        end
    endtask

    task automatic push_directed(input logic cmd, input logic [2:0] kind,
                                 input logic [8:0] bank);
        pending_requests.push_back(t_in_req'{cmd, 2'(pending_requests.size()), kind, bank});
    endtask

    // Waits until the driver has nothing left to offer and every write is in.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_req_valid || expected_writes.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: offers the next pending request unless it idles this cycle. A request
    // taken at this edge is handed to the predictor before the next one goes out,
    // and valid is assigned once per edge so it never dips between requests.
    always @(posedge i_clk) begin : drive_requests
        logic take;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            take = i_req_valid && o_req_ready;
            if (take) begin
                predict_writes(i_req);
                requests_taken++;
            end
            if (take || !i_req_valid) begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
                    i_req       <= pending_requests.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every write taken is checked against the oldest one owed. Once, the
    // receiver stops taking writes for a long stretch so that the block backs up
    // and stops taking requests.
    always @(posedge i_clk) begin : check_writes
        t_out_req want;
        if (!i_rst_n) begin
            i_wr_ready <= 1'b0;
        end else begin
            if (o_wr_valid && i_wr_ready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected write, expected none, actual %h", $time, o_wr);
                    error_count++;
                end else begin
                    want = expected_writes.pop_front();
                    report_field("port_out", 16'(want.port_out), 16'(o_wr.port_out));
                    report_field("write_address", want.write_address, o_wr.write_address);
                    report_field("write_value", 16'(want.write_value), 16'(o_wr.write_value));
                    report_field("last", 16'(want.last), 16'(o_wr.last));
                end
                writes_seen++;
                if (writes_seen == HOLD_AT_WRITE)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_wr_ready <= 1'b0;
            end else begin
                i_wr_ready <= steady || ($urandom_range(99) >= 19);
            end
        end
    end

    initial begin : stimulus
        t_in_req r;

        // ROM bank zero, then MBC1 across the low banks, the aliased banks and
        // the banks whose upper bits go through the upper register.
        push_directed(CMD_ROM, MBC_1, 9'h000);
        push_directed(CMD_ROM, MBC_1, 9'h001);
        push_directed(CMD_ROM, MBC_1, 9'h01F);
        push_directed(CMD_ROM, MBC_1, 9'h020);
        push_directed(CMD_ROM, MBC_1, 9'h040);
        push_directed(CMD_ROM, MBC_1, 9'h060);
        push_directed(CMD_ROM, MBC_1, 9'h021);
        push_directed(CMD_ROM, MBC_1, 9'h07F);
        push_directed(CMD_ROM, MBC_1, 9'h100);
        push_directed(CMD_ROM, MBC_1, 9'h120);
        push_directed(CMD_ROM, MBC_1, 9'h1FF);
        // Other controllers, with bank bits above each mask set.
        push_directed(CMD_ROM, MBC_2, 9'h1FF);
        push_directed(CMD_ROM, MBC_3, 9'h1FF);
        push_directed(CMD_ROM, MBC_5, 9'h1FF);
        push_directed(CMD_ROM, MBC_5, 9'h100);
        push_directed(CMD_ROM, MBC_5, 9'h0FF);
        push_directed(CMD_ROM, MBC_NONE, 9'h055);
        push_directed(CMD_ROM, 3'd5, 9'h1AA);
        push_directed(CMD_ROM, 3'd7, 9'h1AA);
        // RAM switches, including a bank that is zero only in its low byte.
        push_directed(CMD_RAM, MBC_1, 9'h000);
        push_directed(CMD_RAM, MBC_1, 9'h100);
        push_directed(CMD_RAM, MBC_1, 9'h1FF);
        push_directed(CMD_RAM, MBC_3, 9'h0AB);
        push_directed(CMD_RAM, MBC_NONE, 9'h000);
        push_directed(CMD_RAM, 3'd6, 9'h1FF);
        wait_drained();

        // Random requests. Most use the known controller types, and the bank is
        // drawn often from zero and the MBC1 aliased banks.
        for (int half = 0; half < 2; half++) begin
            for (int n = 0; n < RANDOM_PER_HALF; n++) begin
                r.cmd      = 1'($urandom_range(1));
                r.port     = 2'($urandom_range(3));
                r.mbc_type = ($urandom_range(99) < 90) ? 3'($urandom_range(4))
                                                       : 3'($urandom_range(7, 5));
                case ($urandom_range(7))
                    0:       r.bank = 9'd0;
                    1:       r.bank = 9'($urandom_range(3, 1) << 5);
                    2:       r.bank = 9'($urandom_range(31));
                    default: r.bank = 9'($urandom_range(511));
                endcase
                pending_requests.push_back(r);
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
hdl/cbss_pkg.sv
hdl/cbss_front.sv
hdl/cbss_queue.sv
hdl/cbss_back.sv
hdl/cartridge_bank_switch_sequencer_unit.sv
test/tb_top.sv
